// File: rtl/bol_pkg.sv
// ----------------------------------------------------------------------------
// Bounded ordered byte list package
// Shared beat types, operation and status codes, and register map constants.
// ----------------------------------------------------------------------------
package bol_pkg;

  typedef enum logic [2:0] {
    OpAppend = 3'd0,
    OpPop    = 3'd1,
    OpInsert = 3'd2,
    OpDelete = 3'd3,
    OpRead   = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StFull     = 3'd1,
    StEmpty    = 3'd2,
    StNotFound = 3'd3,
    StNoSucc   = 3'd4,
    StBadIdx   = 3'd5
  } status_e;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] value;
    logic [7:0] target;
    logic [2:0] index;
  } item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] data_out;
    logic [3:0] count;
  } result_t;

  typedef struct packed {
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
  } apb_req_t;

  localparam logic       CfgIdxLimit = 1'b0;
  localparam logic [3:0] LimitReset  = 4'd4;

endpackage

// File: rtl/bol_cfg.sv
// ----------------------------------------------------------------------------
// Bounded ordered byte list configuration registers
// APB register file holding the capacity limit of the list.
// ----------------------------------------------------------------------------
module bol_cfg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bol_pkg::apb_req_t apb_i,
  output logic [31:0]       prdata_o,
  output logic [3:0]        limit_o
);

  logic [3:0] limit_q;
  logic [3:0] limit_d;
  logic       reg_idx;
  logic       wr_en;

  assign reg_idx = apb_i.paddr[2];
  assign wr_en   = apb_i.psel & apb_i.penable & apb_i.pwrite;

  always_comb begin
    limit_d = limit_q;
    if (wr_en && reg_idx == bol_pkg::CfgIdxLimit) begin
      limit_d = apb_i.pwdata[3:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= bol_pkg::LimitReset;
    end else begin
      limit_q <= limit_d;
    end
  end

  always_comb begin
    prdata_o = 32'd0;
    if (reg_idx == bol_pkg::CfgIdxLimit) begin
      prdata_o = {28'd0, limit_q};
    end
  end

  assign limit_o = limit_q;

endmodule

// File: rtl/bounded_ordered_byte_list.sv
// ----------------------------------------------------------------------------
// Bounded ordered byte list
// Ordered byte list with append, pop, insert-after, delete-after and read.
// ----------------------------------------------------------------------------
// A command beat is taken when start is high and busy is low; busy then stays
// high until the operation ends. Each command yields one result beat, shown
// for exactly one cycle with result_valid_o high, carrying a status, a data
// byte and the entry count after the operation. The receiver cannot stall.
// Entries live in a memory with one registered read port and one write port,
// and one sequencer walks it one entry per cycle for search and shifting.
// Append and every early error finish with busy never raised. Read performs
// one registered memory read. Pop is a shift pass, and delete-after and
// insert-after are a search pass that compares one entry per cycle up to
// the first match, then a shift pass that moves one entry per cycle;
// insert-after then writes the new byte. The capacity limit register sits
// on the APB port and must be written only while the block is idle, a rule
// for the user that the block itself does not enforce.
// Reset empties the list and sets the limit to 4; no clearing pass is needed.
module bounded_ordered_byte_list #(
  parameter int DEPTH = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              start,
  output logic              busy,
  input  bol_pkg::item_t    cmd_i,
  output logic              result_valid_o,
  output bol_pkg::result_t  result_o
);

  localparam int         AW       = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam logic [3:0] DepthCap = (DEPTH > 15) ? 4'd15 : 4'(DEPTH);

  typedef enum logic [2:0] {
    StIdle,
    StSearch,
    StShDn,
    StShUp,
    StInsWr,
    StRead
  } state_e;

  bol_pkg::apb_req_t apb_req;
  logic [3:0]        limit;
  logic [3:0]        eff;

  state_e            state_q, state_d;
  logic [2:0]        op_q, op_d;
  logic [7:0]        value_q, value_d;
  logic [7:0]        target_q, target_d;
  logic [3:0]        cnt_q, cnt_d;
  logic [3:0]        ptr_q, ptr_d;
  logic [3:0]        pos_q, pos_d;
  logic [3:0]        first_q, first_d;
  logic              pend_q, pend_d;
  logic [3:0]        paddr_q, paddr_d;
  logic              res_valid_q, res_valid_d;
  bol_pkg::result_t  res_q, res_d;

  logic [7:0]        mem_q [DEPTH];
  logic [7:0]        rdata_q;
  logic [AW-1:0]     raddr;
  logic [AW-1:0]     waddr;
  logic [7:0]        wdata;
  logic              we;

  logic              fin;
  bol_pkg::status_e  fin_st;

  assign apb_req = '{psel: psel, penable: penable, pwrite: pwrite,
                     paddr: paddr, pwdata: pwdata};

  bol_cfg u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .apb_i    (apb_req),
    .prdata_o (prdata),
    .limit_o  (limit)
  );

  assign pready = 1'b1;
  assign eff    = (limit < DepthCap) ? limit : DepthCap;

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    value_d     = value_q;
    target_d    = target_q;
    cnt_d       = cnt_q;
    ptr_d       = ptr_q;
    pos_d       = pos_q;
    first_d     = first_q;
    pend_d      = 1'b0;
    paddr_d     = paddr_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    raddr       = AW'(ptr_q);
    we          = 1'b0;
    waddr       = AW'(cnt_q);
    wdata       = value_q;
    fin         = 1'b0;
    fin_st      = bol_pkg::StOk;

    unique case (state_q)
      StIdle: begin
        raddr = AW'(cmd_i.index);
        if (start) begin
          op_d           = cmd_i.op;
          value_d        = cmd_i.value;
          target_d       = cmd_i.target;
          res_d.data_out = 8'd0;
          ptr_d          = 4'd0;
          first_d        = 4'd0;
          unique case (bol_pkg::op_e'(cmd_i.op)) inside
            bol_pkg::OpAppend: begin
              fin = 1'b1;
              if (cnt_q >= eff) begin
                fin_st = bol_pkg::StFull;
              end else begin
                we    = 1'b1;
                waddr = AW'(cnt_q);
                wdata = cmd_i.value;
                cnt_d = cnt_q + 4'd1;
              end
            end
            bol_pkg::OpPop: begin
              if (cnt_q == 4'd0) begin
                fin    = 1'b1;
                fin_st = bol_pkg::StEmpty;
              end else begin
                state_d = StShDn;
              end
            end
            bol_pkg::OpInsert, bol_pkg::OpDelete: begin
              if (cnt_q == 4'd0) begin
                fin    = 1'b1;
                fin_st = bol_pkg::StNotFound;
              end else begin
                state_d = StSearch;
              end
            end
            bol_pkg::OpRead: begin
              if ({1'b0, cmd_i.index} >= cnt_q) begin
                fin    = 1'b1;
                fin_st = bol_pkg::StBadIdx;
              end else begin
                state_d = StRead;
              end
            end
            default: begin
              fin    = 1'b1;
              fin_st = bol_pkg::StBadIdx;
            end
          endcase
        end
      end
      StSearch: begin
        if (ptr_q < cnt_q) begin
          raddr   = AW'(ptr_q);
          ptr_d   = ptr_q + 4'd1;
          pend_d  = 1'b1;
          paddr_d = ptr_q;
        end
        if (pend_q) begin
          if (rdata_q == target_q) begin
            pos_d  = paddr_q;
            pend_d = 1'b0;
            if (op_q == bol_pkg::OpDelete) begin
              if (paddr_q + 4'd1 >= cnt_q) begin
                fin    = 1'b1;
                fin_st = bol_pkg::StNoSucc;
              end else begin
                state_d = StShDn;
                ptr_d   = paddr_q + 4'd1;
                first_d = paddr_q + 4'd1;
              end
            end else begin
              if (cnt_q >= eff) begin
                fin    = 1'b1;
                fin_st = bol_pkg::StFull;
              end else begin
                state_d = StShUp;
                ptr_d   = cnt_q - 4'd1;
              end
            end
          end else if (paddr_q == cnt_q - 4'd1) begin
            fin    = 1'b1;
            fin_st = bol_pkg::StNotFound;
          end
        end
      end
      StShDn: begin
        if (ptr_q < cnt_q) begin
          raddr   = AW'(ptr_q);
          ptr_d   = ptr_q + 4'd1;
          pend_d  = 1'b1;
          paddr_d = ptr_q;
        end
        if (pend_q) begin
          if (paddr_q == first_q) begin
            res_d.data_out = rdata_q;
          end else begin
            we    = 1'b1;
            waddr = AW'(paddr_q - 4'd1);
            wdata = rdata_q;
          end
        end else if (ptr_q == cnt_q) begin
          cnt_d = cnt_q - 4'd1;
          fin   = 1'b1;
        end
      end
      StShUp: begin
        if (ptr_q > pos_q) begin
          raddr   = AW'(ptr_q);
          ptr_d   = ptr_q - 4'd1;
          pend_d  = 1'b1;
          paddr_d = ptr_q;
        end
        if (pend_q) begin
          we    = 1'b1;
          waddr = AW'(paddr_q + 4'd1);
          wdata = rdata_q;
        end else if (ptr_q == pos_q) begin
          state_d = StInsWr;
        end
      end
      StInsWr: begin
        we    = 1'b1;
        waddr = AW'(pos_q + 4'd1);
        wdata = value_q;
        cnt_d = cnt_q + 4'd1;
        fin   = 1'b1;
      end
      StRead: begin
        res_d.data_out = rdata_q;
        fin            = 1'b1;
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    if (fin) begin
      state_d      = StIdle;
      res_valid_d  = 1'b1;
      res_d.status = fin_st;
      if (fin_st != bol_pkg::StOk) begin
        res_d.data_out = 8'd0;
      end
    end
    res_d.count = cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      op_q        <= 3'd0;
      value_q     <= 8'd0;
      target_q    <= 8'd0;
      cnt_q       <= 4'd0;
      ptr_q       <= 4'd0;
      pos_q       <= 4'd0;
      first_q     <= 4'd0;
      pend_q      <= 1'b0;
      paddr_q     <= 4'd0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      value_q     <= value_d;
      target_q    <= target_d;
      cnt_q       <= cnt_d;
      ptr_q       <= ptr_d;
      pos_q       <= pos_d;
      first_q     <= first_d;
      pend_q      <= pend_d;
      paddr_q     <= paddr_d;
      res_valid_q <= res_valid_d;
      res_q       <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  assign busy           = (state_q != StIdle);
  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= DepthCap)
    else $error("Entry count exceeds the storage depth.");

  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("Result beat shown while an operation is still running.");

  a_count_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != $past(cnt_q)) |-> result_valid_o)
    else $error("Entry count changed without a result beat.");

  a_error_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.status != 3'(bol_pkg::StOk)) |->
      (result_o.data_out == 8'd0))
    else $error("Error result carries nonzero data.");

endmodule
